// File: src/pdc_pkg.sv
// Shared types and constants for the Pareto domination counter.
// No dependencies; used by pdc_ctrl, pdc_dp and the top level.
`default_nettype none

package pdc_pkg;

  // Beat field widths (fixed by the stream format)
  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned IN_FIELDS = 4;
  localparam int unsigned IN_DATA_W = 136;  // slot + four objectives, whole bytes
  localparam int unsigned OUT_DATA_W = 16;

  // Configuration register widths and indexes
  localparam int unsigned NOBJ_W     = 3;
  localparam int unsigned NPOP_W     = 9;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_NUM_OBJ  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_POP_SIZE = 1'b1;
  localparam logic [NOBJ_W-1:0] NOBJ_RESET = 3'd2;
  localparam logic [NPOP_W-1:0] NPOP_RESET = 9'd256;

  // Item kinds carried on tuser
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result count
  localparam int unsigned COUNT_W = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

  // Controller to datapath commands
  typedef struct packed {
    logic write;       // store the beat into the table
    logic load_query;  // latch candidate and scan limits
    logic issue;       // read the next table entry
    logic emit;        // move the count into the output register
  } pdc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic npop_zero;   // nothing to scan
    logic last_issue;  // current read address is the final entry
    logic busy;        // reads or compares still in flight
    logic out_free;    // output register can take a result this cycle
  } pdc_stat_t;

endpackage

`default_nettype wire

// File: src/pdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pdc_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: src/pdc_ctrl.sv
// Sequencer for loads and queries of the domination counter.
// Depends on pdc_pkg (command and status structs, item kinds).
`default_nettype none

module pdc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_op_i,
  output logic                  in_ready_o,
  input  wire pdc_pkg::pdc_stat_t stat_i,
  output pdc_pkg::pdc_cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == pdc_pkg::OP_LOAD) begin
            cmd_o.write = 1'b1;
          end else begin
            cmd_o.load_query = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (stat_i.npop_zero) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.issue = 1'b1;
          if (stat_i.last_issue) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!stat_i.busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: src/pdc_dp.sv
// Datapath: candidate latch, scan counter, dominance compare, count and
// output register. Drives the table RAM ports. Depends on pdc_pkg.
`default_nettype none

module pdc_dp #(
  parameter int unsigned MAX_ENTRIES    = 256,
  parameter int unsigned MAX_OBJECTIVES = 4,
  parameter int unsigned VALUE_BITS     = 32
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire pdc_pkg::pdc_cmd_t                         cmd_i,
  output pdc_pkg::pdc_stat_t                             stat_o,
  input  wire logic [pdc_pkg::SLOT_W-1:0]                slot_i,
  input  wire logic [pdc_pkg::IN_FIELDS-1:0][pdc_pkg::FIELD_W-1:0] obj_i,
  input  wire logic [pdc_pkg::NOBJ_W-1:0]                cfg_nobj_i,
  input  wire logic [pdc_pkg::NPOP_W-1:0]                cfg_npop_i,
  // table RAM
  output logic                                           ram_we_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]                 ram_waddr_o,
  output logic [MAX_OBJECTIVES*VALUE_BITS-1:0]           ram_wdata_o,
  output logic                                           ram_re_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]                 ram_raddr_o,
  input  wire logic [MAX_OBJECTIVES*VALUE_BITS-1:0]      ram_rdata_i,
  // result
  output logic                                           out_valid_o,
  input  wire logic                                      out_ready_i,
  output logic [pdc_pkg::COUNT_W-1:0]                    out_count_o,
  output logic                                           out_nondom_o
);

  localparam int unsigned AW    = $clog2(MAX_ENTRIES);
  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES + 1);

  typedef logic [MAX_OBJECTIVES-1:0][VALUE_BITS-1:0] row_t;

  row_t                         beat_row;
  row_t                         rd_row;
  row_t                         cand_q;
  logic [MAX_OBJECTIVES-1:0]    active_q, active_d;
  logic [IDX_W-1:0]             npop_q, npop_d;
  logic [IDX_W-1:0]             idx_q;
  logic                         rd_vld_q, dom_vld_q, dom_q, dom_d;
  logic [pdc_pkg::COUNT_W-1:0]  count_q;
  logic                         out_valid_q;
  logic [pdc_pkg::COUNT_W-1:0]  out_count_q;
  logic                         out_nondom_q;

  // Bring beat objectives to table width; objectives without a field are zero.
  for (genvar j = 0; j < MAX_OBJECTIVES; j++) begin : g_obj
    if (j < pdc_pkg::IN_FIELDS) begin : g_field
      if (VALUE_BITS <= pdc_pkg::FIELD_W) begin : g_trunc
        assign beat_row[j] = obj_i[j][VALUE_BITS-1:0];
      end else begin : g_sext
        assign beat_row[j] = {{(VALUE_BITS - pdc_pkg::FIELD_W){obj_i[j][pdc_pkg::FIELD_W-1]}},
                              obj_i[j]};
      end
    end else begin : g_zero
      assign beat_row[j] = '0;
    end
  end

  assign rd_row = ram_rdata_i;

  // Table write port: out-of-range slots are dropped.
  assign ram_we_o    = cmd_i.write && (32'(slot_i) < 32'(MAX_ENTRIES));
  assign ram_waddr_o = AW'(slot_i);
  assign ram_wdata_o = beat_row;
  assign ram_re_o    = cmd_i.issue;
  assign ram_raddr_o = idx_q[AW-1:0];

  // Scan limits, clamped to the table shape.
  always_comb begin
    for (int j = 0; j < MAX_OBJECTIVES; j++) begin
      active_d[j] = j < int'(cfg_nobj_i);
    end
    if (32'(cfg_npop_i) > 32'(MAX_ENTRIES)) begin
      npop_d = IDX_W'(MAX_ENTRIES);
    end else begin
      npop_d = IDX_W'(cfg_npop_i);
    end
  end

  // Entry dominates: no greater on every active objective, smaller on at least one.
  always_comb begin
    logic no_greater;
    logic some_less;
    no_greater = 1'b1;
    some_less  = 1'b0;
    for (int j = 0; j < MAX_OBJECTIVES; j++) begin
      if (active_q[j]) begin
        if ($signed(rd_row[j]) > $signed(cand_q[j])) begin
          no_greater = 1'b0;
        end
        if ($signed(rd_row[j]) < $signed(cand_q[j])) begin
          some_less = 1'b1;
        end
      end
    end
    dom_d = no_greater && some_less;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_query) begin
      cand_q   <= beat_row;
      active_q <= active_d;
      npop_q   <= npop_d;
      idx_q    <= '0;
      count_q  <= '0;
    end else begin
      if (cmd_i.issue) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (dom_vld_q && dom_q && (count_q != pdc_pkg::COUNT_MAX)) begin
        count_q <= count_q + pdc_pkg::COUNT_W'(1);
      end
    end
    dom_q <= dom_d;
    if (cmd_i.emit) begin
      out_count_q  <= count_q;
      out_nondom_q <= (count_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      dom_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.issue;
      dom_vld_q <= rd_vld_q;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.npop_zero  = (npop_q == '0);
  assign stat_o.last_issue = ((idx_q + IDX_W'(1)) == npop_q);
  assign stat_o.busy       = rd_vld_q || dom_vld_q;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_count_o  = out_count_q;
  assign out_nondom_o = out_nondom_q;

endmodule

`default_nettype wire

// File: src/pareto_domination_counter.sv
// Top level of the Pareto domination counter: stream ports, configuration
// registers, controller, datapath and table RAM.
// Depends on pdc_pkg, pdc_ram, pdc_ctrl and pdc_dp.
// Usage:
//   Input stream (s_axis): tuser selects the beat kind. A load beat writes the
//   four objectives into table entry "slot" and returns nothing; a slot at or
//   beyond MAX_ENTRIES is dropped. A query beat carries a candidate vector and
//   returns one result beat with the number of table entries, among the first
//   N (the population size register), that dominate it under minimization,
//   plus a flag set when that count is zero. Objectives are signed Q16.16.
//   Output stream (m_axis): one beat per query, held in an output register.
//   Sequencing: a load beat is written to the table as it is taken. A
//   query's scan reads one entry per cycle from the table's single read
//   port, then the read and compare registers drain and the result goes valid;
//   the next beat can be taken from the cycle the result goes valid.
//   The next beat is taken while a result still waits in the output register;
//   a stalled receiver only holds up the end of the following query.
//   Configuration: write the objective count (index 0) or the population size
//   (index 1) while idle. Reset gives 2 and 256. Reset leaves the table as is:
//   load every scanned entry before querying.
`default_nettype none

module pareto_domination_counter #(
  parameter int unsigned MAX_ENTRIES    = 256,
  parameter int unsigned MAX_OBJECTIVES = 4,
  parameter int unsigned VALUE_BITS     = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Input beats
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [7:0] slot, [39:8] objective_a, [71:40] objective_b,
  // [103:72] objective_c, [135:104] objective_d
  input  wire logic [pdc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] op
  input  wire logic                               s_axis_tuser,
  // Result beats
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [8:0] dominator_count, [9] is_nondominated, [15:10] zero
  output logic [pdc_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  // Configuration writes
  input  wire logic                               cfg_we_i,
  input  wire logic [pdc_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  wire logic [pdc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned ROW_W = MAX_OBJECTIVES * VALUE_BITS;
  localparam int unsigned AW    = $clog2(MAX_ENTRIES);

  logic [pdc_pkg::NOBJ_W-1:0] nobj_q;
  logic [pdc_pkg::NPOP_W-1:0] npop_q;

  pdc_pkg::pdc_cmd_t  cmd;
  pdc_pkg::pdc_stat_t stat;

  logic [pdc_pkg::SLOT_W-1:0]                               slot;
  logic [pdc_pkg::IN_FIELDS-1:0][pdc_pkg::FIELD_W-1:0]      obj;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;

  logic                        out_nondom;
  logic [pdc_pkg::COUNT_W-1:0] out_count;

  // Configuration registers: take the low bits of the write data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nobj_q <= pdc_pkg::NOBJ_RESET;
      npop_q <= pdc_pkg::NPOP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        pdc_pkg::CFG_NUM_OBJ:  nobj_q <= cfg_data_i[pdc_pkg::NOBJ_W-1:0];
        pdc_pkg::CFG_POP_SIZE: npop_q <= cfg_data_i[pdc_pkg::NPOP_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input beat: slot first, then objectives a..d.
  assign slot = s_axis_tdata[pdc_pkg::SLOT_W-1:0];
  for (genvar j = 0; j < pdc_pkg::IN_FIELDS; j++) begin : g_unpack
    assign obj[j] = s_axis_tdata[pdc_pkg::SLOT_W + j*pdc_pkg::FIELD_W +: pdc_pkg::FIELD_W];
  end

  pdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pdc_dp #(
    .MAX_ENTRIES    (MAX_ENTRIES),
    .MAX_OBJECTIVES (MAX_OBJECTIVES),
    .VALUE_BITS     (VALUE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .slot_i       (slot),
    .obj_i        (obj),
    .cfg_nobj_i   (nobj_q),
    .cfg_npop_i   (npop_q),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_count_o  (out_count),
    .out_nondom_o (out_nondom)
  );

  // One row per table entry, all objectives side by side.
  pdc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Pack the result beat: count low, flag above, zero fill to 16 bits.
  assign m_axis_tdata = {{(pdc_pkg::OUT_DATA_W - pdc_pkg::COUNT_W - 1){1'b0}},
                         out_nondom, out_count};

endmodule

`default_nettype wire
